// ----- rtl/lps_pkg.sv -----
`timescale 1ns / 1ps

package lps_pkg;

    // field widths
    localparam int DW  = 14;               // window / source size
    localparam int XW  = 16;               // signed pointer position
    localparam int OW  = 15;               // absolute output
    localparam int OFW = DW - 1;           // centering offset, (size - extent) / 2
    localparam int PW  = 2 * DW;           // cross product

    // absolute pointer range
    localparam int POINTER_MAX = 32767;
    localparam int OUT_MAX     = (1 << OW) - 1;
    localparam int QW          = $clog2(POINTER_MAX + 1);   // scaled quotient
    localparam int NW          = DW + QW;                   // scaling dividend

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QAW     = $clog2(Q_DEPTH);

    // register map, index = paddr[AW-1:2]
    localparam int AW = 4;
    localparam logic [1:0] REG_WIN_W = 2'd0;
    localparam logic [1:0] REG_WIN_H = 2'd1;
    localparam logic [1:0] REG_SRC_W = 2'd2;
    localparam logic [1:0] REG_SRC_H = 2'd3;

    typedef struct packed {
        logic [DW-1:0] win_w;
        logic [DW-1:0] win_h;
        logic [DW-1:0] src_w;
        logic [DW-1:0] src_h;
    } t_cfg;

    // view rectangle as the front needs it: extent - 1 and offset per axis
    typedef struct packed {
        logic           ok;
        logic [DW-1:0]  den_x;
        logic [DW-1:0]  den_y;
        logic [OFW-1:0] off_x;
        logic [OFW-1:0] off_y;
    } t_view;

    typedef struct packed {
        logic [DW-1:0] pos;
        logic [DW-1:0] den;
    } t_axis;

    typedef struct packed {
        logic  ok;
        t_axis x;
        t_axis y;
    } t_job;

endpackage

// ----- rtl/lps_in_if.sv -----
`timescale 1ns / 1ps

interface lps_in_if import lps_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic signed [XW-1:0] ptr_x;
    logic signed [XW-1:0] ptr_y;

    modport source (output valid, ptr_x, ptr_y, input ready);
    modport sink   (input valid, ptr_x, ptr_y, output ready);
endinterface

// ----- rtl/lps_out_if.sv -----
`timescale 1ns / 1ps

interface lps_out_if import lps_pkg::*; ();
    logic          valid;
    logic          ready;
    logic          emit_valid;
    logic [OW-1:0] abs_x;
    logic [OW-1:0] abs_y;

    modport source (output valid, emit_valid, abs_x, abs_y, input ready);
    modport sink   (input valid, emit_valid, abs_x, abs_y, output ready);
endinterface

// ----- rtl/lps_geom.sv -----
`timescale 1ns / 1ps

module lps_geom import lps_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_wr,
    input  t_cfg  i_cfg,
    output t_view o_view,
    output logic  o_busy
);

    localparam int CW = $clog2(PW);

    typedef enum logic [2:0] {S_MUL, S_SEL, S_DIV, S_FIN, S_IDLE} t_state;

    t_state        r_state;
    logic [PW-1:0] r_a;
    logic [PW-1:0] r_b;
    logic          r_wide;
    logic [PW-1:0] r_num;       // dividend, shifts into quotient
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dsr;
    logic [CW-1:0] r_cnt;
    t_view         r_view;

    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] lim;
    logic [DW-1:0] ext;
    logic          lbox;
    logic [DW-1:0] vw;
    logic [DW-1:0] vh;
    logic [DW-1:0] slack_w;
    logic [DW-1:0] slack_h;
    t_view         n_view;

    // one restoring step
    always_comb begin
        trial = {r_rem, r_num[PW-1]};
        diff  = trial - {1'b0, r_dsr};
        ge    = (trial >= {1'b0, r_dsr});
    end

    // clamp quotient, pick extents, center
    always_comb begin
        lim = r_wide ? i_cfg.win_w : i_cfg.win_h;
        if (r_num == '0) begin
            ext = DW'(1);
        end else if (r_num > PW'(lim)) begin
            ext = lim;
        end else begin
            ext = r_num[DW-1:0];
        end
        lbox    = (i_cfg.src_w != '0) && (i_cfg.src_h != '0) && (r_a != r_b);
        vw      = (lbox && r_wide)  ? ext : i_cfg.win_w;
        vh      = (lbox && !r_wide) ? ext : i_cfg.win_h;
        slack_w = i_cfg.win_w - vw;
        slack_h = i_cfg.win_h - vh;
        n_view.ok    = (i_cfg.win_w != '0) && (i_cfg.win_h != '0);
        n_view.den_x = vw - DW'(1);
        n_view.den_y = vh - DW'(1);
        n_view.off_x = slack_w[DW-1:1];
        n_view.off_y = slack_h[DW-1:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_MUL;
            r_view.ok <= 1'b0;
        end else if (i_cfg_wr) begin
            r_state <= S_MUL;
        end else begin
            case (r_state)
                S_MUL: begin
                    r_a     <= PW'(i_cfg.win_w) * PW'(i_cfg.src_h);
                    r_b     <= PW'(i_cfg.win_h) * PW'(i_cfg.src_w);
                    r_state <= S_SEL;
                end
                S_SEL: begin
                    r_wide  <= (r_a > r_b);
                    r_num   <= (r_a > r_b) ? r_b : r_a;
                    r_dsr   <= (r_a > r_b) ? i_cfg.src_h : i_cfg.src_w;
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
                    r_num <= {r_num[PW-2:0], ge};
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(PW - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_view  <= n_view;
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_MUL;
                end
            endcase
        end
    end

    assign o_view = r_view;
    assign o_busy = (r_state != S_IDLE);

    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr |=> o_busy)
        else $error("view not recomputed after register write");

    a_view_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_busy && o_view.ok) |->
            (o_view.den_x < i_cfg.win_w) && (o_view.den_y < i_cfg.win_h))
        else $error("view extent outside window");

endmodule

// ----- rtl/lps_front.sv -----
`timescale 1ns / 1ps

module lps_front import lps_pkg::*; (
    input  logic      i_hold,
    input  t_view     i_view,
    input  logic      i_q_full,
    lps_in_if.sink    i_ptr,
    output logic      o_push,
    output t_job      o_job
);

    localparam int SW = XW + 1;

    // shift into view coordinates and clamp to 0..den
    function automatic logic [DW-1:0] clamp_axis(logic signed [XW-1:0] p,
                                                 logic [OFW-1:0] off,
                                                 logic [DW-1:0] den);
        logic signed [SW-1:0] s;
        s = $signed({p[XW-1], p}) - $signed({{(SW-OFW){1'b0}}, off});
        if (s < 0) begin
            return '0;
        end else if (s > $signed({{(SW-DW){1'b0}}, den})) begin
            return den;
        end else begin
            return s[DW-1:0];
        end
    endfunction

    assign i_ptr.ready = !i_hold && !i_q_full;
    assign o_push      = i_ptr.valid && i_ptr.ready;

    always_comb begin
        o_job.ok    = i_view.ok;
        o_job.x.den = i_view.den_x;
        o_job.y.den = i_view.den_y;
        o_job.x.pos = clamp_axis(i_ptr.ptr_x, i_view.off_x, i_view.den_x);
        o_job.y.pos = clamp_axis(i_ptr.ptr_y, i_view.off_y, i_view.den_y);
    end

endmodule

// ----- rtl/lps_queue.sv -----
`timescale 1ns / 1ps

module lps_queue import lps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_vld,
    output t_job o_job
);

    t_job           r_mem [Q_DEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QAW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + (QAW+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QAW+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full = (r_cnt == (QAW+1)'(Q_DEPTH));
    assign o_vld  = (r_cnt != '0);
    assign o_job  = r_mem[r_rp];

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

endmodule

// ----- rtl/lps_back.sv -----
`timescale 1ns / 1ps

module lps_back import lps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_job_vld,
    input  t_job       i_job,
    output logic       o_pop,
    lps_out_if.source  o_res
);

    localparam int QBW  = $clog2(QW);
    localparam int SATW = QW + OW;

    typedef struct packed {
        logic [NW-1:0] num;
        logic [DW-1:0] den;
        logic [DW-1:0] rem;
        logic [QW-1:0] q;
    } t_lane;

    typedef struct packed {
        logic  ok;
        t_lane x;
        t_lane y;
    } t_stage;

    // pos * POINTER_MAX + round; top bits start the remainder
    function automatic t_lane lane_init(t_axis a);
        t_lane l;
        l.num = NW'(a.pos) * NW'(POINTER_MAX) + NW'(a.den >> 1);
        l.den = a.den;
        l.rem = l.num[NW-1:QW];
        l.q   = '0;
        return l;
    endfunction

    function automatic t_lane div_step(t_lane l, logic [QBW-1:0] b);
        t_lane      r;
        logic [DW:0] trial;
        r     = l;
        trial = {l.rem, l.num[b]};
        if (trial >= {1'b0, l.den}) begin
            r.rem  = DW'(trial - {1'b0, l.den});
            r.q[b] = 1'b1;
        end else begin
            r.rem = trial[DW-1:0];
        end
        return r;
    endfunction

    function automatic logic [OW-1:0] axis_out(logic ok, t_lane l);
        if (!ok || l.den == '0) begin
            return '0;
        end else if (SATW'(l.q) > SATW'(OUT_MAX)) begin
            return OW'(OUT_MAX);
        end else begin
            return OW'(l.q);
        end
    endfunction

    logic [QW:0] r_vld;
    t_stage      r_stg [0:QW];
    t_stage      n_stg [0:QW];
    logic        en;

    assign en    = !r_vld[QW] || o_res.ready;
    assign o_pop = en && i_job_vld;

    always_comb begin
        n_stg[0].ok = i_job.ok;
        n_stg[0].x  = lane_init(i_job.x);
        n_stg[0].y  = lane_init(i_job.y);
        for (int k = 1; k <= QW; k++) begin
            n_stg[k].ok = r_stg[k-1].ok;
            n_stg[k].x  = div_step(r_stg[k-1].x, QBW'(QW - k));
            n_stg[k].y  = div_step(r_stg[k-1].y, QBW'(QW - k));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[QW-1:0], o_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_stg <= n_stg;
        end
    end

    assign o_res.valid      = r_vld[QW];
    assign o_res.emit_valid = r_stg[QW].ok;
    assign o_res.abs_x      = axis_out(r_stg[QW].ok, r_stg[QW].x);
    assign o_res.abs_y      = axis_out(r_stg[QW].ok, r_stg[QW].y);

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[QW] && r_stg[QW].x.den != '0) |-> (r_stg[QW].x.rem < r_stg[QW].x.den))
        else $error("x divider remainder out of range");

    a_q_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[QW] && r_stg[QW].y.den != '0) |-> (r_stg[QW].y.q <= QW'(POINTER_MAX)))
        else $error("y quotient above pointer maximum");

endmodule

// ----- rtl/letterbox_pointer_scaler.sv -----
`timescale 1ns / 1ps

// Letterbox pointer scaler. Each input word carries a signed pointer position
// in window pixels; each output word carries the position mapped onto
// 0..POINTER_MAX through the centred view of the remote picture, with
// emit_valid low (and both coordinates 0) while either window size is zero.
// Throughput is one word per clock while the output is ready and the view is
// not being recomputed. Words pass through the queue, where the scaled
// dividend is formed on its way into the first stage, then through one
// restoring-division stage per quotient bit (15 for the default range), both
// axes side by side. The view rectangle is recomputed after reset and after
// every register write by a bit-serial divider (cross products, select, 28
// division steps, finish); the input is not ready in the write cycle itself
// and while the divider runs. The output sits in a register, and a 4-word
// queue lets the input keep accepting while a result waits. Registers sit at
// byte addresses 0x0 (window width), 0x4 (window height), 0x8 (source width),
// 0xC (source height), 14 bits each, readable back; write them only while
// no word is in flight.

module letterbox_pointer_scaler import lps_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lps_in_if.sink        i_ptr,
    lps_out_if.source     o_res,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [AW-1:0] paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    t_cfg  r_cfg;
    logic  cfg_wr;
    t_view view;
    logic  busy;
    logic  q_full;
    logic  q_vld;
    logic  q_pop;
    logic  push;
    t_job  push_job;
    t_job  q_job;

    // APB register file: write on the access phase, zero wait states
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (cfg_wr) begin
            case (paddr[AW-1:2])
                REG_WIN_W: r_cfg.win_w <= pwdata[DW-1:0];
                REG_WIN_H: r_cfg.win_h <= pwdata[DW-1:0];
                REG_SRC_W: r_cfg.src_w <= pwdata[DW-1:0];
                REG_SRC_H: r_cfg.src_h <= pwdata[DW-1:0];
                default:   r_cfg       <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (paddr[AW-1:2])
            REG_WIN_W: prdata = 32'(r_cfg.win_w);
            REG_WIN_H: prdata = 32'(r_cfg.win_h);
            REG_SRC_W: prdata = 32'(r_cfg.src_w);
            REG_SRC_H: prdata = 32'(r_cfg.src_h);
            default:   prdata = '0;
        endcase
    end

    // view rectangle, recomputed whenever the registers change
    lps_geom u_geom (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_cfg    (r_cfg),
        .o_view   (view),
        .o_busy   (busy)
    );

    // front: offset and clamp into the view; held off while the view settles
    lps_front u_front (
        .i_hold   (busy || cfg_wr),
        .i_view   (view),
        .i_q_full (q_full),
        .i_ptr    (i_ptr),
        .o_push   (push),
        .o_job    (push_job)
    );

    lps_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_job    (push_job),
        .i_pop    (q_pop),
        .o_full   (q_full),
        .o_vld    (q_vld),
        .o_job    (q_job)
    );

    // back: scale with rounding through the pipelined divider
    lps_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job_vld (q_vld),
        .i_job     (q_job),
        .o_pop     (q_pop),
        .o_res     (o_res)
    );

endmodule

// ----- tb/letterbox_pointer_scaler_tb.sv -----
`timescale 1ns / 1ps

module letterbox_pointer_scaler_tb import lps_pkg::*; ();

    // one expected output word
    typedef struct packed {
        logic          emit_valid;
        logic [OW-1:0] abs_x;
        logic [OW-1:0] abs_y;
    } t_ptr_word;

    // directed row: view registers, pointer, and a hand-written answer where one is obvious
    typedef struct packed {
        t_cfg                 view;
        logic signed [XW-1:0] px;
        logic signed [XW-1:0] py;
        logic                 known;
        t_ptr_word            want;
    } t_probe;

    typedef enum logic [1:0] {RDY_OPEN, RDY_LIGHT, RDY_HEAVY, RDY_PATTERN} t_sink_mode;
    typedef enum logic [2:0] {
        VIEW_TYPICAL, VIEW_EXTREME, VIEW_NO_WINDOW, VIEW_NO_SOURCE, VIEW_WIDE
    } t_view_kind;

    localparam int          STALL_LIMIT   = 5000;    // quiet cycles before the watchdog fires
    localparam int          TAIL_CYCLES   = 40;      // longer than the pipeline latency
    localparam int          PHASES        = 14;
    localparam int          WORDS_PER_PH  = 50;
    localparam int          MAX_ERR_LINES = 40;
    localparam logic [15:0] STALL_PATTERN = 16'b1100_1011_0001_1110;

    localparam logic [1:0] REG_ORDER [4] = '{REG_WIN_W, REG_WIN_H, REG_SRC_W, REG_SRC_H};

    // view settings used by the directed rows: {win_w, win_h, src_w, src_h}
    localparam t_cfg CFG_RESET  = '0;
    localparam t_cfg CFG_FLAT0  = '{14'd100, 14'd0, 14'd0, 14'd0};
    localparam t_cfg CFG_THIN0  = '{14'd0, 14'd100, 14'd0, 14'd0};
    localparam t_cfg CFG_MAXWIN = '{14'd16383, 14'd16383, 14'd0, 14'd0};
    localparam t_cfg CFG_DOT    = '{14'd1, 14'd1, 14'd0, 14'd0};
    localparam t_cfg CFG_COLUMN = '{14'd1, 14'd16383, 14'd0, 14'd0};
    localparam t_cfg CFG_WIDE   = '{14'd200, 14'd100, 14'd100, 14'd100};   // pillarbox
    localparam t_cfg CFG_TALL   = '{14'd100, 14'd200, 14'd100, 14'd100};   // letterbox
    localparam t_cfg CFG_SAME   = '{14'd200, 14'd100, 14'd400, 14'd200};   // equal aspect
    localparam t_cfg CFG_NOSRCW = '{14'd300, 14'd200, 14'd0, 14'd50};
    localparam t_cfg CFG_NOSRCH = '{14'd300, 14'd200, 14'd50, 14'd0};
    localparam t_cfg CFG_SLIVER = '{14'd16383, 14'd1, 14'd1, 14'd16383};  // width clamps to 1
    localparam t_cfg CFG_BAND   = '{14'd16383, 14'd16383, 14'd16383, 14'd1};
    localparam t_cfg CFG_ODD    = '{14'd3, 14'd2, 14'd16383, 14'd16383};

    localparam t_ptr_word W_OFF    = '0;
    localparam t_ptr_word W_ORIGIN = '{1'b1, '0, '0};
    localparam t_ptr_word W_FAR    = '{1'b1, OW'(POINTER_MAX), OW'(POINTER_MAX)};

    localparam int N_PROBES = 24;
    localparam t_probe PROBES [N_PROBES] = '{
        // reset view: window size zero, nothing valid
        '{CFG_RESET,  16'sd0,     16'sd0,     1'b1, W_OFF},
        '{CFG_RESET,  16'sd32767, 16'sh8000,  1'b1, W_OFF},
        // one window dimension zero
        '{CFG_FLAT0,  16'sd10,    16'sd10,    1'b1, W_OFF},
        '{CFG_THIN0,  16'sd10,    16'sd10,    1'b1, W_OFF},
        // largest window, no source: corners and far-outside positions
        '{CFG_MAXWIN, 16'sd0,     16'sd0,     1'b1, W_ORIGIN},
        '{CFG_MAXWIN, 16'sd16382, 16'sd16382, 1'b1, W_FAR},
        '{CFG_MAXWIN, 16'sh8000,  16'sh8000,  1'b1, W_ORIGIN},
        '{CFG_MAXWIN, 16'sd32767, 16'sd32767, 1'b1, W_FAR},
        '{CFG_MAXWIN, 16'sd8191,  -16'sd1,    1'b0, W_OFF},
        // extent of one on one or both axes
        '{CFG_DOT,    16'sd5,     -16'sd5,    1'b1, W_ORIGIN},
        '{CFG_COLUMN, 16'sd0,     16'sd16382, 1'b1, '{1'b1, '0, OW'(POINTER_MAX)}},
        // side bars: view 100 wide at offset 50
        '{CFG_WIDE,   16'sd50,    16'sd0,     1'b1, W_ORIGIN},
        '{CFG_WIDE,   16'sd149,   16'sd99,    1'b1, W_FAR},
        '{CFG_WIDE,   16'sd0,     16'sd50,    1'b0, W_OFF},
        '{CFG_WIDE,   16'sd100,   16'sd50,    1'b0, W_OFF},
        // top/bottom bars: view 100 high at offset 50
        '{CFG_TALL,   16'sd0,     16'sd50,    1'b1, W_ORIGIN},
        '{CFG_TALL,   16'sd99,    16'sd149,   1'b1, W_FAR},
        '{CFG_TALL,   16'sd40,    16'sd120,   1'b0, W_OFF},
        // matching aspect and zero source sizes: whole window
        '{CFG_SAME,   16'sd199,   16'sd99,    1'b1, W_FAR},
        '{CFG_NOSRCW, 16'sd150,   16'sd100,   1'b0, W_OFF},
        '{CFG_NOSRCH, -16'sd7,    16'sd250,   1'b0, W_OFF},
        // degenerate views from extreme sources
        '{CFG_SLIVER, 16'sd8191,  16'sd0,     1'b1, W_ORIGIN},
        '{CFG_BAND,   16'sd16382, 16'sd0,     1'b1, '{1'b1, OW'(POINTER_MAX), '0}},
        '{CFG_ODD,    16'sd1,     16'sd1,     1'b0, W_OFF}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    // APB side
    logic          psel;
    logic          penable;
    logic          pwrite;
    logic [AW-1:0] paddr;
    logic [31:0]   pwdata;
    logic [31:0]   prdata;
    logic          pready;

    lps_in_if  ptr_if ();
    lps_out_if res_if ();

    letterbox_pointer_scaler i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ptr   (ptr_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // scoreboard state
    t_ptr_word  pending_words [$];
    t_ptr_word  head_word;
    t_cfg       view        = '0;   // what the registers hold right now
    int         n_errors    = 0;
    int         n_checked   = 0;
    int         n_sent      = 0;
    int         n_views     = 0;
    int         burst_left  = 0;
    int         quiet_count = 0;
    t_sink_mode rdy_mode    = RDY_OPEN;
    int         rdy_left    = 0;
    logic [3:0] rdy_phase   = '0;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (n_errors < MAX_ERR_LINES)
            $display("MISMATCH t=%0t word %0d: %s got %0d want %0d",
                     $time, n_checked, what, got, want);
        n_errors++;
    endtask

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    // Clamp into 0..extent-1, scale onto 0..POINTER_MAX with round-to-nearest.
    function automatic logic [OW-1:0] scale_coord(input int pos, input int extent);
        longint q;
        if (extent <= 1)
            return '0;                      // single-pixel extent pins to 0
        if (pos < 0)
            pos = 0;
        if (pos > extent - 1)
            pos = extent - 1;
        q = (longint'(pos) * POINTER_MAX + (extent - 1) / 2) / (extent - 1);
        if (q > OUT_MAX)
            q = OUT_MAX;
        return q[OW-1:0];
    endfunction

    function automatic t_ptr_word map_pointer(input t_cfg c, input logic signed [XW-1:0] px,
                                              input logic signed [XW-1:0] py);
        t_ptr_word r;
        int        ww, wh, sw, sh, vw, vh, vx, vy;
        longint    a, b, span;
        r  = '0;
        ww = c.win_w;
        wh = c.win_h;
        sw = c.src_w;
        sh = c.src_h;
        if (ww == 0 || wh == 0)
            return r;                       // no window: emit_valid low, coords 0
        vw = ww;
        vh = wh;
        vx = 0;
        vy = 0;
        // aspect fit only when both source sizes are known
        if (sw != 0 && sh != 0) begin
            a = longint'(ww) * sh;
            b = longint'(wh) * sw;
            if (a > b) begin
                span = b / sh;
                vw   = (span < 1) ? 1 : (span > ww) ? ww : int'(span);
                vx   = (ww - vw) / 2;
            end else if (a < b) begin
                span = a / sw;
                vh   = (span < 1) ? 1 : (span > wh) ? wh : int'(span);
                vy   = (wh - vh) / 2;
            end
        end
        r.emit_valid = 1'b1;
        r.abs_x      = scale_coord(int'(px) - vx, vw);
        r.abs_y      = scale_coord(int'(py) - vy, vh);
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------

    // One APB transfer: setup, then access until pready. It ends on the following edge so
    // the next transfer never re-drives psel in the same step.
    task automatic apb_xfer(input bit wr, input logic [1:0] idx, input logic [DW-1:0] val,
                            output logic [31:0] rdata);
        logic [31:0] junk;
        junk = $urandom;                    // upper bits are don't-care for the registers
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk[31:DW], val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all four view registers, then read them back.
    task automatic load_view(input t_cfg c);
        logic [DW-1:0] vals [4];
        logic [31:0]   rd;
        vals = '{c.win_w, c.win_h, c.src_w, c.src_h};
        for (int i = 0; i < 4; i++)
            apb_xfer(1'b1, REG_ORDER[i], vals[i], rd);
        view = c;
        n_views++;
        for (int i = 0; i < 4; i++) begin
            apb_xfer(1'b0, REG_ORDER[i], '0, rd);
            if (rd !== {{(32 - DW){1'b0}}, vals[i]})
                report_mismatch("register readback", rd, {{(32 - DW){1'b0}}, vals[i]});
        end
    endtask

    // Drop valid for a span set by n; the payload carries noise meanwhile.
    task automatic hold_input(input int n);
        ptr_if.valid <= 1'b0;
        ptr_if.ptr_x <= XW'($urandom);
        ptr_if.ptr_y <= XW'($urandom);
        repeat (n) @(posedge i_clk);
    endtask

    // Offer one pointer word; record the expected result on accept.
    // Bursts: short ones mostly, now and then a long gap-free stretch.
    task automatic push_ptr(input logic signed [XW-1:0] px, input logic signed [XW-1:0] py,
                            input logic known, input t_ptr_word want);
        t_ptr_word exp_w;
        exp_w = known ? want : map_pointer(view, px, py);
        ptr_if.valid <= 1'b1;
        ptr_if.ptr_x <= px;
        ptr_if.ptr_y <= py;
        do @(posedge i_clk); while (!ptr_if.ready);
        pending_words.insert(pending_words.size(), exp_w);
        n_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            hold_input($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Sender idle until every expected word is back.
    task automatic wait_drained();
        while (pending_words.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [DW-1:0] extreme_size();
        case ($urandom_range(0, 2))
            0:       return 14'd1;
            1:       return 14'd16383;
            default: return DW'($urandom_range(1, 16383));
        endcase
    endfunction

    // ---------------------------------------------------------------------
    // Receiver: ready follows one of several stall habits, switched at random
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rdy_left == 0) begin
            rdy_mode <= t_sink_mode'($urandom_range(0, 3));
            rdy_left <= $urandom_range(16, 160);
        end else begin
            rdy_left <= rdy_left - 1;
        end
        rdy_phase <= rdy_phase + 4'd1;
        case (rdy_mode)
            RDY_OPEN:  res_if.ready <= 1'b1;
            RDY_LIGHT: res_if.ready <= ($urandom_range(0, 3) != 0);
            RDY_HEAVY: res_if.ready <= ($urandom_range(0, 3) == 0);
            default:   res_if.ready <= STALL_PATTERN[rdy_phase];
        endcase
    end

    // ---------------------------------------------------------------------
    // Output check: each accepted word against the oldest expectation
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_words.size() == 0) begin
                report_mismatch("word with nothing pending", 1, 0);
            end else begin
                head_word = pending_words.pop_front();
                if (res_if.emit_valid !== head_word.emit_valid)
                    report_mismatch("emit_valid", res_if.emit_valid, head_word.emit_valid);
                if (res_if.abs_x !== head_word.abs_x)
                    report_mismatch("abs_x", res_if.abs_x, head_word.abs_x);
                if (res_if.abs_y !== head_word.abs_y)
                    report_mismatch("abs_y", res_if.abs_y, head_word.abs_y);
                n_checked++;
            end
        end
    end

    // Watchdog: any handshake or APB access counts as progress.
    always @(posedge i_clk) begin
        if ((ptr_if.valid && ptr_if.ready) || (res_if.valid && res_if.ready) ||
            (psel && penable))
            quiet_count <= 0;
        else
            quiet_count <= quiet_count + 1;
        if (quiet_count >= STALL_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles, %0d words outstanding",
                     quiet_count, pending_words.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin : stimulus
        t_cfg                 nv;
        t_view_kind           kind;
        int                   rx, ry;
        logic signed [XW-1:0] px, py;

        // everything known from time zero
        i_rst_n      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        ptr_if.valid = 1'b0;
        ptr_if.ptr_x = '0;
        ptr_if.ptr_y = '0;
        res_if.ready = 1'b0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table. Rows start on the reset view; a new view is loaded only
        // once the pipe is empty (registers must not move under a word in flight).
        for (int r = 0; r < N_PROBES; r++) begin
            if (PROBES[r].view != view) begin
                hold_input(1);
                wait_drained();
                load_view(PROBES[r].view);
            end
            push_ptr(PROBES[r].px, PROBES[r].py, PROBES[r].known, PROBES[r].want);
        end

        // Random phases: new view each phase, then a run of pointer words.
        for (int ph = 0; ph < PHASES; ph++) begin
            hold_input(1);
            wait_drained();

            case ($urandom_range(0, 9))
                0:       kind = VIEW_EXTREME;
                1:       kind = VIEW_NO_WINDOW;
                2:       kind = VIEW_NO_SOURCE;
                3:       kind = VIEW_WIDE;
                default: kind = VIEW_TYPICAL;
            endcase
            // small sizes keep letterbox offsets and clamps inside reach
            nv.win_w = DW'($urandom_range(1, 400));
            nv.win_h = DW'($urandom_range(1, 400));
            nv.src_w = DW'($urandom_range(1, 400));
            nv.src_h = DW'($urandom_range(1, 400));
            case (kind)
                VIEW_EXTREME: begin
                    nv.win_w = extreme_size();
                    nv.win_h = extreme_size();
                    nv.src_w = extreme_size();
                    nv.src_h = extreme_size();
                end
                VIEW_NO_WINDOW: begin
                    case ($urandom_range(0, 2))
                        0:       nv.win_w = '0;
                        1:       nv.win_h = '0;
                        default: begin
                            nv.win_w = '0;
                            nv.win_h = '0;
                        end
                    endcase
                end
                VIEW_NO_SOURCE: begin
                    case ($urandom_range(0, 2))
                        0:       nv.src_w = '0;
                        1:       nv.src_h = '0;
                        default: begin
                            nv.src_w = '0;
                            nv.src_h = '0;
                        end
                    endcase
                end
                VIEW_WIDE: begin
                    nv.win_w = DW'($urandom_range(1, 16383));
                    nv.win_h = DW'($urandom_range(1, 16383));
                    nv.src_w = DW'($urandom_range(1, 16383));
                    nv.src_h = DW'($urandom_range(1, 16383));
                end
                default: ;
            endcase
            load_view(nv);

            for (int k = 0; k < WORDS_PER_PH; k++) begin
                // mid-phase full drain at least once, randomly elsewhere
                if (k == WORDS_PER_PH / 2 && (ph == 3 || $urandom_range(0, 3) == 0)) begin
                    hold_input(1);
                    wait_drained();
                end
                // mostly around the window (including just outside), else anywhere
                if ($urandom_range(0, 9) < 7) begin
                    rx = int'($urandom_range(0, view.win_w + 40)) - 20;
                    ry = int'($urandom_range(0, view.win_h + 40)) - 20;
                    px = rx[XW-1:0];
                    py = ry[XW-1:0];
                end else begin
                    px = XW'($urandom);
                    py = XW'($urandom);
                end
                push_ptr(px, py, 1'b0, W_OFF);
            end
        end

        hold_input(1);
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_words.size() != 0)
            report_mismatch("words never produced", pending_words.size(), 0);

        $display("Checked %0d pointer words (%0d sent) across %0d view settings,",
                 n_checked, n_sent, n_views);
        $display("directed corners plus random views, with bursty input and stalled output.");
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
